### src/lgs_pkg.sv
// Package for the Life generation step block: shared types, constants and codes.
// Used by lgs_cell, lgs_window and the top level; depends on nothing.
`timescale 1ns / 1ps

package lgs_pkg;

  // Default size limits of the grid.
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  // Configuration register widths and reset values.
  localparam int unsigned GRID_WIDTH_BITS   = 9;
  localparam int unsigned GRID_HEIGHT_BITS  = 11;
  localparam int unsigned GRID_WIDTH_RESET  = 200;
  localparam int unsigned GRID_HEIGHT_RESET = 200;

  // Stream and register bus widths.
  localparam int unsigned TDATA_BITS = 8;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned APB_ADDR_BITS = 3;

  // Register index codes, taken from paddr[2].
  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_e;

  // One column entry of the line stores: the cell two rows up and one row up.
  typedef struct packed {
    logic upper;
    logic middle;
  } pair_t;

  // Control from the top level to the 3x3 window.
  typedef struct packed {
    logic shift;      // take the new column
    logic clear;      // restart the frame
    logic col_ge1;    // input column at least 1
    logic col_ge2;    // input column at least 2
    logic width_ge2;  // grid at least two cells wide
  } win_ctrl_t;

endpackage

### src/lgs_cell.sv
// One cell of the line store chain: holds the upper and middle bits of one column.
// Depends on lgs_pkg for the pair type.
`timescale 1ns / 1ps

module lgs_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          head_i,
  input  lgs_pkg::pair_t push_i,
  input  lgs_pkg::pair_t prev_i,
  output lgs_pkg::pair_t q_o
);
  import lgs_pkg::*;

  pair_t cell_q;
  pair_t cell_d;

  // The head cell takes the new entry; every other cell takes its left neighbor.
  always_comb begin
    cell_d = head_i ? push_i : prev_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

### src/lgs_window.sv
// The 3x3 window of the Life step: two stored columns, neighbor count and rule.
// Depends on lgs_pkg for the control struct.
`timescale 1ns / 1ps

module lgs_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lgs_pkg::win_ctrl_t ctrl_i,
  input  logic [2:0]        newcol_i,
  output logic              next_alive_o
);
  import lgs_pkg::*;

  logic [5:0] win_q;
  logic [5:0] win_d;
  logic [2:0] older;
  logic [2:0] newer;
  logic [3:0] side_cnt;
  logic [3:0] ncount;

  function automatic logic [3:0] count3(input logic [2:0] col);
    count3 = {3'b000, col[0]} + {3'b000, col[1]} + {3'b000, col[2]};
  endfunction

  assign older = win_q[5:3];
  assign newer = win_q[2:0];

  // Neighbors: the center column without its center, plus the side columns present.
  always_comb begin
    if (ctrl_i.col_ge1) begin
      side_cnt = count3(newcol_i) + (ctrl_i.col_ge2 ? count3(older) : 4'd0);
    end else begin
      side_cnt = ctrl_i.width_ge2 ? count3(older) : 4'd0;
    end
    ncount = count3(newer & 3'b101) + side_cnt;
  end

  // Birth on three, survival on two or three.
  always_comb begin
    if (newer[1]) begin
      next_alive_o = (ncount == 4'd2) || (ncount == 4'd3);
    end else begin
      next_alive_o = (ncount == 4'd3);
    end
  end

  // Window shift; a frame restart wins over the shift.
  always_comb begin
    win_d = win_q;
    if (ctrl_i.clear) begin
      win_d = '0;
    end else if (ctrl_i.shift) begin
      win_d = {newer, newcol_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

endmodule

### src/life_generation_step_top.sv
// Top level of the Life generation step: counters, line store chain, window, output.
// Depends on lgs_pkg, lgs_cell and lgs_window.
// Throughput: one item per cycle while no result stalls; the output register frees
// itself as it is taken. The result for a cell comes with the item grid_width + 1
// places later and shows on the output in the cycle after that item is accepted.
// Reset clears counters, window and output valid, and sets both sizes to 200.
`timescale 1ns / 1ps

module life_generation_step_top #(
  parameter int unsigned MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // bit 0: cell_alive, bits 7:1 zero
  input  logic        s_axis_tuser,   // bit 0: kind
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // bit 0: next_alive, bits 7:1 zero
  output logic        m_axis_tlast,   // frame_last
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lgs_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned WCMP = (WW > GRID_WIDTH_BITS) ? WW : GRID_WIDTH_BITS;
  localparam int unsigned HCMP = (HW > GRID_HEIGHT_BITS) ? HW : GRID_HEIGHT_BITS;

  // Configuration registers, held as written.
  logic [GRID_WIDTH_BITS-1:0]  width_raw_q;
  logic [GRID_HEIGHT_BITS-1:0] height_raw_q;
  logic                        cfg_wr;
  reg_idx_e                    cfg_idx;

  // Effective sizes.
  logic [WCMP-1:0] width_ext;
  logic [HCMP-1:0] height_ext;
  logic [WW-1:0]   width_eff;
  logic [HW-1:0]   height_eff;
  logic [CW-1:0]   head_idx;

  // Position counters.
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // Item datapath.
  logic      accept;
  logic      flush;
  logic      ignore;
  logic      shift;
  logic      cell_v;
  logic      up_bit;
  logic      mid_bit;
  logic [2:0] newcol;
  logic      emit;
  logic      frame_last;
  logic      restart;
  logic      col_wrap;
  logic      next_alive;
  pair_t     push;
  pair_t     tail;
  win_ctrl_t win_ctrl;

  // Output register.
  logic out_valid_q, out_valid_d;
  logic out_data_q;
  logic out_last_q;

  // APB access: always ready, write on the access phase.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      REG_GRID_WIDTH:  prdata = 32'(width_raw_q);
      REG_GRID_HEIGHT: prdata = 32'(height_raw_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_raw_q  <= GRID_WIDTH_BITS'(GRID_WIDTH_RESET);
      height_raw_q <= GRID_HEIGHT_BITS'(GRID_HEIGHT_RESET);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GRID_WIDTH:  width_raw_q  <= pwdata[GRID_WIDTH_BITS-1:0];
        REG_GRID_HEIGHT: height_raw_q <= pwdata[GRID_HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A size of zero counts as one; a size above the limit counts as the limit.
  always_comb begin
    width_ext  = WCMP'(width_raw_q);
    height_ext = HCMP'(height_raw_q);
    if (width_ext == '0) begin
      width_eff = WW'(1);
    end else if (width_ext > WCMP'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(width_ext);
    end
    if (height_ext == '0) begin
      height_eff = HW'(1);
    end else if (height_ext > HCMP'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(height_ext);
    end
  end

  // The chain holds the last grid_width entries; it starts at this cell.
  assign head_idx = CW'(WW'(MAX_WIDTH) - width_eff);

  // Handshake: a new item is taken whenever the output register can move on.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Item decode. A flush before any cell of the frame is dropped.
  assign flush   = s_axis_tuser;
  assign ignore  = flush && (col_q == '0) && (row_q == '0);
  assign shift   = accept && !ignore;
  assign cell_v  = !flush && (row_q < RW'(height_eff)) && s_axis_tdata[0];
  assign up_bit  = (row_q >= RW'(2)) && tail.upper;
  assign mid_bit = (row_q >= RW'(1)) && tail.middle;
  assign newcol  = {cell_v, mid_bit, up_bit};
  assign push    = '{upper: mid_bit, middle: cell_v};

  // The result for the grid's final cell comes with column zero two rows past it.
  assign emit       = (col_q != '0) ? (row_q >= RW'(1)) : (row_q >= RW'(2));
  assign frame_last = (col_q == '0) && (row_q == RW'(height_eff) + RW'(1));
  assign restart    = shift && emit && frame_last;
  assign col_wrap   = (WW'(col_q) + WW'(1)) >= width_eff;

  // Position counters, cleared at the end of a frame or on a register write.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_wr || restart) begin
      col_d = '0;
      row_d = '0;
    end else if (shift) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line store chain: one cell per column, shifting once per item that is not dropped.
  pair_t chain [MAX_WIDTH];

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_chain
    if (k == 0) begin : g_first
      lgs_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (shift),
        .head_i (head_idx == CW'(k)),
        .push_i (push),
        .prev_i (push),
        .q_o    (chain[k])
      );
    end else begin : g_rest
      lgs_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (shift),
        .head_i (head_idx == CW'(k)),
        .push_i (push),
        .prev_i (chain[k-1]),
        .q_o    (chain[k])
      );
    end
  end

  assign tail = chain[MAX_WIDTH-1];

  // Window and rule.
  always_comb begin
    win_ctrl.shift     = shift;
    win_ctrl.clear     = cfg_wr || restart;
    win_ctrl.col_ge1   = (col_q >= CW'(1));
    win_ctrl.col_ge2   = (col_q >= CW'(2));
    win_ctrl.width_ge2 = (width_eff >= WW'(2));
  end

  lgs_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (win_ctrl),
    .newcol_i     (newcol),
    .next_alive_o (next_alive)
  );

  // Output register: loads a result item, drops valid once it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (shift && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift && emit) begin
      out_data_q <= next_alive;
      out_last_q <= frame_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0000000, out_data_q};
  assign m_axis_tlast  = out_last_q;

endmodule

### src/lgs_checker.sv
// Port-level checks for the Life generation step top level, with its bind.
// Depends on life_generation_step_top's port list only.
`timescale 1ns / 1ps

module lgs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // The input side is open whenever no result waits.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  // A new result only follows an accepted input item.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result item without an accepted input item");

  // The padding bits of a result item are zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'b0000000))
    else $error("result padding bits not zero");

endmodule

bind life_generation_step_top lgs_checker u_lgs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

### sim/life_step_checker.sv
// Checker for the Life generation step: watches the cell stream, the result stream and
// register writes, predicts every next-generation cell and compares it with the block.
// Depends on lgs_pkg for the register codes, default sizes and reset values.
`timescale 1ns / 1ps

module life_step_checker #(
  parameter int unsigned MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // bit 0: cell_alive, bits 7:1 zero
  input  logic        s_axis_tuser,   // bit 0: kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // bit 0: next_alive, bits 7:1 zero
  input  logic        m_axis_tlast,   // frame_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import lgs_pkg::*;

  typedef struct packed {
    logic next_alive;
    logic frame_last;
  } next_cell_t;

  // Model copy of the registers and of the window state.
  logic [GRID_WIDTH_BITS-1:0]  width_reg;
  logic [GRID_HEIGHT_BITS-1:0] height_reg;
  bit                          upper_row [MAX_WIDTH];
  bit                          middle_row [MAX_WIDTH];
  logic [5:0]                  window_cols;
  int unsigned                 col_pos;
  int unsigned                 row_pos;
  int unsigned                 cells_out;

  // Next-generation cells still owed by the block, oldest first.
  next_cell_t next_cells [$];

  function automatic int unsigned clamp_dim(int unsigned raw, int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic void restart_frame();
    window_cols = '0;
    col_pos     = 0;
    row_pos     = 0;
    cells_out   = 0;
  endfunction

  // Advance the window by one accepted item and queue the cell it completes, if any.
  function automatic void predict_next_cell(bit flush, bit alive);
    int unsigned w, h, total, cin, rin, n;
    bit          v, up, mid, produce, done;
    logic [2:0]  newcol, older, newer;
    next_cell_t  res;
    w     = clamp_dim(32'(width_reg), MAX_WIDTH);
    h     = clamp_dim(32'(height_reg), MAX_HEIGHT);
    total = w * h;
    done  = 1'b0;
    // A flush before any cell of a frame does nothing.
    if (flush && col_pos == 0 && row_pos == 0) return;
    cin = (col_pos >= w) ? w - 1 : col_pos;
    rin = row_pos;
    // Flushes and cells past the last row enter as dead cells.
    v      = (!flush && rin < h) ? alive : 1'b0;
    up     = (rin >= 2) ? upper_row[cin] : 1'b0;
    mid    = (rin >= 1) ? middle_row[cin] : 1'b0;
    newcol = {v, mid, up};
    older  = window_cols[5:3];
    newer  = window_cols[2:0];
    produce = (cin >= 1) ? (rin >= 1) : (rin >= 2);
    if (produce && cells_out < total) begin
      // The center cell sits in the middle of the newer column.
      n = 32'(newer[0]) + 32'(newer[2]);
      if (cin >= 1) begin
        if (cin >= 2) n += $countones(older);
        n += $countones(newcol);
      end else if (w >= 2) begin
        n += $countones(older);
      end
      res.next_alive = newer[1] ? (n == 2 || n == 3) : (n == 3);
      res.frame_last = (cells_out + 1 == total);
      next_cells.push_back(res);
      cells_out++;
      done = res.frame_last;
    end
    upper_row[cin]  = mid;
    middle_row[cin] = v;
    window_cols     = {newer, newcol};
    if (cin + 1 >= w) begin
      col_pos = 0;
      row_pos = rin + 1;
    end else begin
      col_pos = cin + 1;
      row_pos = rin;
    end
    if (done) restart_frame();
  endfunction

  // Results are checked before the item of the same edge is predicted: a result
  // always leaves in a later cycle than the item that causes it.
  always @(posedge clk_i or negedge rst_ni) begin
    next_cell_t want;
    if (!rst_ni) begin
      width_reg  = GRID_WIDTH_BITS'(GRID_WIDTH_RESET);
      height_reg = GRID_HEIGHT_BITS'(GRID_HEIGHT_RESET);
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i]  = 1'b0;
        middle_row[i] = 1'b0;
      end
      restart_frame();
      next_cells.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (next_cells.size() == 0) begin
          $error("result with no cell expected: next_alive %0d frame_last %0d",
                 m_axis_tdata[0], m_axis_tlast);
          fail_count_o++;
        end else begin
          want = next_cells.pop_front();
          if (m_axis_tdata[0] !== want.next_alive) begin
            $error("next_alive: expected %0d, got %0d", want.next_alive, m_axis_tdata[0]);
            fail_count_o++;
          end
          if (m_axis_tlast !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, m_axis_tlast);
            fail_count_o++;
          end
        end
      end
      // A register write resizes the grid and starts a new frame.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[2]))
          REG_GRID_WIDTH: begin
            width_reg = pwdata[GRID_WIDTH_BITS-1:0];
            restart_frame();
          end
          REG_GRID_HEIGHT: begin
            height_reg = pwdata[GRID_HEIGHT_BITS-1:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_next_cell(s_axis_tuser, s_axis_tdata[0]);
      pending_o = next_cells.size();
    end
  end

endmodule

### sim/testbench.sv
// Top of the Life generation step test: clock, reset, cell stimulus, result stalls,
// register writes and the verdict. Depends on lgs_pkg, life_step_checker and the block.
`timescale 1ns / 1ps

module testbench;
  import lgs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned ITEM_TARGET = 1250;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = 3'd0;
  logic [31:0] pwdata        = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned items_fed;
  bit          tx_steady;
  bit          rx_steady;

  life_generation_step_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  life_step_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned grid_dim(int unsigned raw, int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // Result side: random stalls unless a steady stretch is running.
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 7) == 0) stall = gap_len();
      end
    end
  end

  // Send one item and return at the edge where it is taken.
  task automatic feed_cell(bit kind, bit alive);
    int unsigned gap;
    gap = tx_steady ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, alive};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_fed++;
  endtask

  // Stop sending and wait until every owed result has left the block.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stream the first cells of a frame; a whole frame is followed by the padding
  // that pushes its last row out.
  task automatic stream_frame(int unsigned w, int unsigned h, int unsigned cells);
    int unsigned density;
    density = $urandom_range(10, 90);
    for (int unsigned k = 0; k < cells; k++) begin
      // Now and then a flush lands inside the grid and stands for a dead cell.
      if (k > 0 && $urandom_range(0, 39) == 0) feed_cell(1'b1, 1'($urandom_range(0, 1)));
      else feed_cell(1'b0, $urandom_range(0, 99) < density);
    end
    if (cells == w * h) begin
      for (int unsigned k = 0; k <= w; k++)
        feed_cell($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
      // A flush on an idle frame must be dropped.
      if ($urandom_range(0, 4) == 0) feed_cell(1'b1, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned w_raw, h_raw, w_eff, h_eff, pick, frames, phase;
    items_fed = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes of 200 by 200: only the first row's early cells come out.
    for (int k = 0; k < 215; k++) feed_cell(1'b0, 1'($urandom_range(0, 1)));

    // 3x3 grid: ignored idle flush, a flush inside the grid, live cells past the grid.
    write_reg(REG_GRID_WIDTH, 32'd3);
    write_reg(REG_GRID_HEIGHT, 32'd3);
    feed_cell(1'b1, 1'b1);
    feed_cell(1'b0, 1'b1); feed_cell(1'b0, 1'b1); feed_cell(1'b0, 1'b0);
    feed_cell(1'b0, 1'b0); feed_cell(1'b1, 1'b1); feed_cell(1'b0, 1'b1);
    feed_cell(1'b0, 1'b1); feed_cell(1'b0, 1'b1); feed_cell(1'b0, 1'b1);
    feed_cell(1'b0, 1'b1); feed_cell(1'b0, 1'b1); feed_cell(1'b1, 1'b0);
    feed_cell(1'b1, 1'b1);
    // Zero sizes count as a single cell.
    write_reg(REG_GRID_WIDTH, 32'd0);
    write_reg(REG_GRID_HEIGHT, 32'd0);
    feed_cell(1'b0, 1'b1); feed_cell(1'b0, 1'b1); feed_cell(1'b1, 1'b1);

    // Random phases: mostly small whole frames, a few extreme sizes and cut frames.
    phase = 0;
    while (items_fed < ITEM_TARGET) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (phase == 0) pick = 81;
      else if (phase == 1) pick = 83;
      else pick = $urandom_range(0, 99);
      if (pick < 68) begin
        w_raw = $urandom_range(1, 12);
        h_raw = $urandom_range(1, 8);
      end else if (pick < 75) begin
        w_raw = $urandom_range(0, 1);
        h_raw = $urandom_range(1, 6);
      end else if (pick < 81) begin
        w_raw = $urandom_range(1, 20);
        h_raw = 0;
      end else if (pick < 83) begin
        w_raw = $urandom_range(0, 1) ? 511 : $urandom_range(256, 300);
        h_raw = 1;
      end else if (pick < 88) begin
        w_raw = $urandom_range(1, 2);
        h_raw = $urandom_range(0, 1) ? 2047 : $urandom_range(1024, 1500);
      end else begin
        w_raw = $urandom_range(2, 9);
        h_raw = $urandom_range(2, 6);
      end
      // Bits above each register's width are sometimes set and must be dropped.
      write_reg(REG_GRID_WIDTH,
                {($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'd0, 9'(w_raw)});
      write_reg(REG_GRID_HEIGHT,
                {($urandom_range(0, 3) == 0) ? 21'($urandom) : 21'd0, 11'(h_raw)});
      w_eff = grid_dim(w_raw & 9'h1FF, MAX_WIDTH_DEF);
      h_eff = grid_dim(h_raw & 11'h7FF, MAX_HEIGHT_DEF);
      if (pick >= 83 && pick < 88) begin
        stream_frame(w_eff, h_eff, $urandom_range(20, 60));
      end else if (pick >= 88) begin
        stream_frame(w_eff, h_eff, $urandom_range(1, w_eff * h_eff - 1));
      end else begin
        frames = (pick >= 81) ? 1 : $urandom_range(1, 3);
        for (int unsigned f = 0; f < frames; f++) begin
          stream_frame(w_eff, h_eff, w_eff * h_eff);
          if ($urandom_range(0, 3) == 0) drain_results();
        end
      end
      phase++;
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
src/lgs_pkg.sv
src/lgs_cell.sv
src/lgs_window.sv
src/life_generation_step_top.sv
src/lgs_checker.sv
sim/life_step_checker.sv
sim/testbench.sv
